/* rtl/core/anp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII number parser package
// Shared widths, character codes, phase and radix codes and payload types.
// ----------------------------------------------------------------------------
package anp_pkg;

    // Width of the value that must hold the parsed number (8 to 64).
    localparam int VALUE_WIDTH = 64;
    // Width of the value field on the result channel.
    localparam int DATA_W      = 64;
    // Room for value * 16 + 15 without losing the carry out.
    localparam int WIDE_W      = VALUE_WIDTH + 4;

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_ZERO  = 3'd1;
    localparam logic [2:0] PH_DIGIT = 3'd2;
    localparam logic [2:0] PH_TRAIL = 3'd3;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;

    localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       end_of_text;
    } parse_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] parsed_value;
        logic              number_ok;
    } parse_result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage
`default_nettype wire

/* rtl/core/anp_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII number parser input stage
// Registers one character transfer and holds it until the parse core uses it.
// ----------------------------------------------------------------------------
module anp_in_stage
    import anp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ascii_char
    input  wire logic        s_tlast,   // end_of_text
    input  wire logic        consume,
    output logic             item_valid,
    output parse_item_t      item
);

    logic        valid_reg;
    logic        valid_next;
    parse_item_t item_reg;

    // The register may be refilled in the same cycle in which it is drained.
    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (consume) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.ascii_char  <= s_tdata;
            item_reg.end_of_text <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

/* rtl/core/anp_parse_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII number parser core
// Folds one character per cycle into its state; a last one waits for out_ready.
// ----------------------------------------------------------------------------
module anp_parse_core
    import anp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire parse_item_t  in_item,
    input  wire logic         out_ready,
    output logic              consume,
    output logic              res_valid,
    output parse_result_t     res
);

    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;
    logic [1:0]             base_reg;
    logic [1:0]             base_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic                   err_reg;
    logic                   err_next;

    logic [7:0]        c;
    logic [1:0]        eff_base;
    logic              is_dec;
    logic              is_hex;
    logic [3:0]        digit;
    logic [WIDE_W-1:0] scaled;
    logic [WIDE_W-1:0] sum;
    logic              overflow;
    logic              too_big;
    logic              fold_ok;

    // A character without the end mark never produces a result, so it can
    // always be taken; the final one waits for room in the output stage.
    assign consume = in_valid && (!in_item.end_of_text || out_ready);
    assign c       = in_item.ascii_char;

    // A digit in the leading phase is always decimal, one after a lone zero
    // is always octal.
    always_comb begin
        case (phase_reg)
            PH_LEAD: eff_base = BASE_DEC;
            PH_ZERO: eff_base = BASE_OCT;
            default: eff_base = base_reg;
        endcase
    end

    assign is_dec = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_hex = (eff_base == BASE_HEX) && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F);
    assign digit  = is_dec ? c[3:0] : 4'(c[3:0] + HEX_LETTER_OFFSET);

    always_comb begin
        case (eff_base)
            BASE_OCT: scaled = WIDE_W'({acc_reg, 3'b000});
            BASE_HEX: scaled = WIDE_W'({acc_reg, 4'b0000});
            default:  scaled = WIDE_W'({acc_reg, 3'b000}) + WIDE_W'({acc_reg, 1'b0});
        endcase
    end

    assign sum      = scaled + WIDE_W'(digit);
    assign overflow = |sum[WIDE_W-1:VALUE_WIDTH];
    assign too_big  = (eff_base == BASE_OCT) && digit[3];
    assign fold_ok  = !too_big && !overflow;

    always_comb begin
        phase_next = phase_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (consume) begin
            if (!err_reg) begin
                case (phase_reg)
                    PH_LEAD: begin
                        if (is_blank(c)) begin
                            phase_next = PH_LEAD;
                        end else if (c == CHAR_MINUS) begin
                            err_next = 1'b1;
                        end else if (c == CHAR_ZERO) begin
                            phase_next = PH_ZERO;
                        end else begin
                            base_next  = BASE_DEC;
                            phase_next = PH_DIGIT;
                        end
                    end
                    PH_ZERO: begin
                        phase_next = PH_DIGIT;
                        base_next  = (c == CHAR_LOWER_X) ? BASE_HEX : BASE_OCT;
                    end
                    PH_DIGIT: begin
                        phase_next = PH_DIGIT;
                    end
                    default: begin
                        phase_next = PH_TRAIL;
                        err_next   = !is_blank(c);
                    end
                endcase

                // Digit handling shared by the leading, zero and digit phases.
                if ((phase_reg == PH_DIGIT)
                    || ((phase_reg == PH_LEAD) && !is_blank(c) && (c != CHAR_MINUS)
                        && (c != CHAR_ZERO))
                    || ((phase_reg == PH_ZERO) && (c != CHAR_LOWER_X))) begin
                    if (is_dec || is_hex) begin
                        if (fold_ok) begin
                            acc_next = sum[VALUE_WIDTH-1:0];
                        end else begin
                            err_next = 1'b1;
                        end
                    end else begin
                        phase_next = PH_TRAIL;
                        err_next   = !is_blank(c);
                    end
                end
            end

            if (in_item.end_of_text) begin
                res_valid     = 1'b1;
                res.number_ok = !err_next && (phase_next != PH_LEAD);
                res.parsed_value = res.number_ok ? DATA_W'(acc_next) : '0;
                phase_next = PH_LEAD;
                base_next  = BASE_DEC;
                acc_next   = '0;
                err_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            base_reg  <= BASE_DEC;
            acc_reg   <= '0;
            err_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
        end
    end

    // The value only starts to build once the leading phase is left.
    a_lead_acc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LEAD) |-> (acc_reg == '0))
        else $error("accumulator not zero in leading phase");

    // After the final character every piece of state is back at reset.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_item.end_of_text) |=>
            (phase_reg == PH_LEAD) && (base_reg == BASE_DEC) && !err_reg)
        else $error("state not cleared after end of text");

    // An error stays until the text ends.
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg && !(consume && in_item.end_of_text)) |=> err_reg)
        else $error("error flag dropped within a text");

    // A final character is never taken while the output stage is full.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_ready)
        else $error("result produced without room in output stage");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg <= PH_TRAIL) && (base_reg <= BASE_HEX))
        else $error("phase or radix code out of range");

endmodule
`default_nettype wire

/* rtl/core/anp_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII number parser output stage
// Result register that holds a parsed number until the receiver takes it.
// ----------------------------------------------------------------------------
module anp_out_stage
    import anp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              res_valid,
    input  wire parse_result_t     res,
    output logic                   out_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // [63:0] parsed_value
    output logic                   m_tuser    // number_ok
);

    logic          valid_reg;
    logic          valid_next;
    parse_result_t res_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (res_valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.parsed_value;
    assign m_tuser  = res_reg.number_ok;

endmodule
`default_nettype wire

/* rtl/core/ascii_number_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII number parser
// Parses an unsigned decimal, octal or hexadecimal text, one character a
// transfer, into a value and a valid flag.
// ----------------------------------------------------------------------------
// The input stream carries one character per transfer in s_tdata, with
// s_tlast set on the final character of a text. For each text exactly one
// result transfer appears on the output stream: m_tdata holds the value and
// m_tuser is high when the text was a valid number (the value is zero
// otherwise). Blanks around the number are skipped, a leading 0 selects
// octal and a leading 0x hexadecimal with uppercase digits only.
// A character is one transfer per cycle: the input register feeds the parse
// logic, which folds it into the accumulator (a shift-and-add by 8, 10 or
// 16 plus the overflow test), so the input sustains one character every
// clock unless a final character waits for room. Each result enters the
// output register as its final character leaves the input register.
// While the receiver stalls, the input still takes characters that do not end
// a text; a final character waits in the input register until output has room.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// parser to the start of a text.
// ----------------------------------------------------------------------------
module ascii_number_parser
    import anp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] ascii_char
    input  wire logic               s_tlast,   // end_of_text
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [DATA_W-1:0]       m_tdata,   // [63:0] parsed_value
    output logic                    m_tuser    // number_ok
);

    logic          item_valid;
    parse_item_t   item;
    logic          consume;
    logic          out_ready;
    logic          res_valid;
    parse_result_t res;

    anp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    anp_parse_core u_parse_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_valid),
        .in_item   (item),
        .out_ready (out_ready),
        .consume   (consume),
        .res_valid (res_valid),
        .res       (res)
    );

    anp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ASCII number parser testbench
// Streams number texts into the parser one character per transfer, predicts
// the value and valid flag of every text, and compares each result transfer
// with the oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import anp_pkg::*;

    localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [7:0]  CHAR_NUL     = 8'h00;
    localparam logic [7:0]  CHAR_TOP     = 8'hFF;
    localparam logic [63:0] VALUE_MAX    = {64{1'b1}} >> (64 - VALUE_WIDTH);
    localparam int          HOLD_CYCLES  = 300;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;

    // Predictor state for the text in progress.
    logic [2:0]  cur_phase = PH_LEAD;
    logic [1:0]  cur_base  = BASE_DEC;
    logic [63:0] cur_value = '0;
    logic        cur_bad   = 1'b0;

    parse_result_t pending_numbers[$];
    logic [7:0]    text_buf[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    logic          hold_off       = 1'b0;

    ascii_number_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("** ascii_number_parser: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 20) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic logic blank_char(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // A character that is not a decimal digit or, in hex, A to F ends the digits
    // and must be a blank; a digit too big for the radix makes the text bad.
    task automatic fold_digit(input logic [7:0] c);
        logic [63:0] digit;
        logic [63:0] radix;
        radix = (cur_base == BASE_OCT) ? 64'd8 : (cur_base == BASE_HEX) ? 64'd16 : 64'd10;
        digit = '0;
        if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
            digit = 64'(c - CHAR_ZERO);
        end else if ((cur_base == BASE_HEX) && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
            digit = 64'(c - CHAR_UPPER_A) + 64'd10;
        end else begin
            cur_phase = PH_TRAIL;
            if (!blank_char(c)) cur_bad = 1'b1;
            return;
        end
        if ((digit >= radix) || (cur_value > (VALUE_MAX - digit) / radix)) begin
            cur_bad = 1'b1;
        end else begin
            cur_value = cur_value * radix + digit;
        end
    endtask

    task automatic predict_char(input logic [7:0] c, input logic last);
        logic ok;
        if (!cur_bad) begin
            case (cur_phase)
                PH_LEAD: begin
                    if (!blank_char(c)) begin
                        if (c == CHAR_MINUS) begin
                            cur_bad = 1'b1;
                        end else if (c == CHAR_ZERO) begin
                            cur_phase = PH_ZERO;
                        end else begin
                            cur_base  = BASE_DEC;
                            cur_phase = PH_DIGIT;
                            fold_digit(c);
                        end
                    end
                end
                PH_ZERO: begin
                    cur_phase = PH_DIGIT;
                    if (c == CHAR_LOWER_X) begin
                        cur_base = BASE_HEX;
                    end else begin
                        cur_base = BASE_OCT;
                        fold_digit(c);
                    end
                end
                PH_DIGIT: begin
                    fold_digit(c);
                end
                default: begin
                    cur_phase = PH_TRAIL;
                    if (!blank_char(c)) cur_bad = 1'b1;
                end
            endcase
        end
        if (last) begin
            ok = !cur_bad && (cur_phase != PH_LEAD);
            pending_numbers.push_back('{parsed_value: ok ? DATA_W'(cur_value) : '0,
                                        number_ok: ok});
            cur_phase = PH_LEAD;
            cur_base  = BASE_DEC;
            cur_value = '0;
            cur_bad   = 1'b0;
        end
    endtask

    // Result checking and receiver stalls.
    always @(posedge aclk) begin
        parse_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_numbers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: value %h flag %b",
                                              m_tdata, m_tuser));
                end else begin
                    want = pending_numbers.pop_front();
                    if (m_tdata !== want.parsed_value) begin
                        report_mismatch($sformatf("value %h, expected %h",
                                                  m_tdata, want.parsed_value));
                    end
                    if (m_tuser !== want.number_ok) begin
                        report_mismatch($sformatf("valid flag %b, expected %b",
                                                  m_tuser, want.number_ok));
                    end
                end
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_char(c, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Always waits on the clock before checking, so that valid is never lowered and
    // raised again within the same time step.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_numbers.size() != 0);
    endtask

    function automatic logic [7:0] digit_char(input logic [63:0] d);
        return (d < 10) ? CHAR_ZERO + 8'(d) : CHAR_UPPER_A + 8'(d - 10);
    endfunction

    function automatic logic [7:0] any_blank();
        return ($urandom_range(5) == 0) ? CHAR_SPACE : CHAR_TAB + 8'($urandom_range(4));
    endfunction

    task automatic push_digits(input logic [63:0] v, input logic [63:0] radix);
        int at;
        at = text_buf.size();
        do begin
            text_buf.insert(at, digit_char(v % radix));
            v = v / radix;
        end while (v != 0);
    endtask

    // Mostly well-formed numbers with random content, some borderline on the
    // value range, plus odd short texts and plain noise.
    task automatic build_text();
        logic [63:0] radix;
        logic [63:0] v;
        int          kind;
        kind = $urandom_range(99);
        repeat ($urandom_range(2)) text_buf.push_back(any_blank());
        if (kind < 70) begin
            case ($urandom_range(2))
                0:       radix = 10;
                1:       radix = 8;
                default: radix = 16;
            endcase
            if (radix != 10) text_buf.push_back(CHAR_ZERO);
            if (radix == 16) text_buf.push_back(CHAR_LOWER_X);
            if ($urandom_range(9) == 0) begin
                v = VALUE_MAX / radix + 64'($urandom_range(1));
                push_digits(v, radix);
                text_buf.push_back(digit_char(64'($urandom_range(32'(radix) - 1))));
            end else begin
                v = ({$urandom, $urandom} >> $urandom_range(63)) & VALUE_MAX;
                push_digits(v, radix);
            end
            repeat ($urandom_range(2)) text_buf.push_back(any_blank());
            if ($urandom_range(9) == 0) begin
                text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
            end
        end else if (kind < 85) begin
            case ($urandom_range(7))
                0: text_buf.push_back(CHAR_ZERO);
                1: begin
                    text_buf.push_back(CHAR_ZERO);
                    text_buf.push_back(CHAR_LOWER_X);
                end
                2: begin
                    text_buf.push_back(CHAR_MINUS);
                    text_buf.push_back(digit_char(64'($urandom_range(9))));
                end
                3: text_buf.push_back(any_blank());
                4: begin
                    text_buf.push_back(CHAR_ZERO);
                    text_buf.push_back(CHAR_LOWER_X);
                    text_buf.push_back(CHAR_LOWER_A + 8'($urandom_range(5)));
                end
                5: begin
                    text_buf.push_back(CHAR_ZERO);
                    text_buf.push_back(digit_char(64'($urandom_range(8, 9))));
                end
                6: begin
                    text_buf.push_back(digit_char(64'($urandom_range(9))));
                    text_buf.push_back(any_blank());
                    text_buf.push_back(digit_char(64'($urandom_range(9))));
                end
                default: text_buf.push_back(CHAR_NUL);
            endcase
            repeat ($urandom_range(1)) text_buf.push_back(any_blank());
        end else begin
            repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic send_random_texts(input int n_chars);
        int sent;
        sent = 0;
        while (sent < n_chars) begin
            build_text();
            foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
            sent += text_buf.size();
            text_buf.delete();
        end
    endtask

    task automatic test_special_cases();
        send_text("0");
        send_text("-7");
        send_text(" ");
        send_text("0x");
        send_text("0 ");
        send_text("0x ");
        send_text("019");
        send_text("1a");
        send_text("0xAF");
        send_text("5 x");
        send_char(CHAR_NUL, 1'b1);
        send_char(CHAR_TOP, 1'b1);
        pause_until_drained();
    endtask

    task automatic test_random_texts(input int idle_pct, input int stall_pct,
                                     input int n_chars);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        send_random_texts(n_chars);
        pause_until_drained();
    endtask

    // The receiver holds off while characters keep coming, so that a final
    // character has to wait and the input stalls.
    task automatic test_receiver_hold_off();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
            send_random_texts(150);
        join
        pause_until_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_special_cases();
        test_random_texts(0, 0, 450);
        test_random_texts(67, 0, 400);
        test_random_texts(0, 67, 400);
        test_random_texts(11, 11, 450);
        test_receiver_hold_off();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** ascii_number_parser: PASSED **");
        end else begin
            $display("** ascii_number_parser: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/anp_pkg.sv
rtl/core/anp_in_stage.sv
rtl/core/anp_parse_core.sv
rtl/core/anp_out_stage.sv
rtl/core/ascii_number_parser.sv
sim/testbench.sv
